### sv/joint_pd_filtered_derivative_assert.svh
// Assertion macros shared by the joint PD controller RTL.
`ifndef JOINT_PD_FILTERED_DERIVATIVE_ASSERT_SVH
`define JOINT_PD_FILTERED_DERIVATIVE_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define JPD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define JPD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jpd_pkg.sv
// Package with widths, constants, types and helpers of the joint PD controller.
`default_nettype none
package jpd_pkg;

  localparam int NUM_JOINTS_DEF  = 7;
  localparam int GAIN_COUNT      = 7;
  localparam int ANGLE_FRAC_BITS = 14;

  localparam int JOINT_W    = 3;
  localparam int ANGLE_W    = 18;
  localparam int DIFF_W     = ANGLE_W + 1;
  localparam int VEL_W      = 28;
  localparam int VRAW_W     = VEL_W + 1;
  localparam int KP_W       = 12;
  localparam int KD_W       = 10;
  localparam int P_W        = 31;
  localparam int SUM_W      = 40;
  localparam int TORQUE_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd7;

  localparam logic signed [9:0] VEL_GAIN = 10'sd400;

  // Round-to-nearest divide by five: floor((|v| + 2) * DIV5_MUL / 2**DIV5_SHIFT).
  localparam int VMAG_W     = VEL_W;
  localparam int DIV5_MUL_W = 29;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 29'd429496730;
  localparam int DIV5_SHIFT = 31;
  localparam int QPROD_W    = VMAG_W + DIV5_MUL_W;
  localparam int Q_W        = QPROD_W - DIV5_SHIFT;

  localparam int SCALE_UP   = (ANGLE_FRAC_BITS <= 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam int SCALE_DN   = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam int SCALE_HALF = (1 << SCALE_DN) >> 1;
  localparam int T_W        = SUM_W + 1 + SCALE_UP;

  localparam longint HOME_DEN = 18000;

  typedef logic [GAIN_COUNT-1:0][KP_W-1:0] kp_bank_t;

  localparam kp_bank_t KP_RESET = {12'd500, 12'd500, 12'd500, 12'd700,
                                   12'd500, 12'd500, 12'd500};
  localparam logic [KD_W-1:0] KD_RESET = 10'd10;

  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic                    inr;
    logic                    clip;
    logic signed [VEL_W-1:0] vel;
    logic signed [P_W-1:0]   pterm;
  } jpd_mid_t;

  function automatic int eff_joints(input int n);
    eff_joints = (n < GAIN_COUNT) ? n : GAIN_COUNT;
  endfunction

  function automatic int idx_width(input int n);
    idx_width = (n > 1) ? $clog2(n) : 1;
  endfunction

  // Home pose angle of a joint in the angle format, rounded and saturated.
  function automatic logic signed [ANGLE_W-1:0] home_angle(input int j);
    longint deg;
    longint num;
    longint h;
    case (j)
      0: deg = 90;
      1: deg = -7;
      2: deg = -13;
      3: deg = 108;
      4: deg = -90;
      5: deg = -90;
      6: deg = 116;
      default: deg = 0;
    endcase
    num = deg * 314 * (64'sd1 <<< ANGLE_FRAC_BITS);
    if (num >= 0) h = (num + HOME_DEN / 2) / HOME_DEN;
    else h = -((-num + HOME_DEN / 2) / HOME_DEN);
    if (h > 131071) h = 131071;
    if (h < -131072) h = -131072;
    home_angle = ANGLE_W'(h);
  endfunction

endpackage
`default_nettype wire

### sv/jpd_vel.sv
// Front stages: per-joint state, dirty-derivative velocity and proportional term.
`default_nettype none
module jpd_vel import jpd_pkg::*; #(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [JOINT_W-1:0]        in_joint_index,
  input  wire logic signed [ANGLE_W-1:0] in_measured_angle,
  input  wire logic signed [ANGLE_W-1:0] in_reference_angle,
  input  wire kp_bank_t                  kp,
  output logic                           mid_valid,
  input  wire logic                      mid_ready,
  output jpd_mid_t                       mid
);

  localparam int NJ    = eff_joints(NUM_JOINTS);
  localparam int IDX_W = idx_width(NJ);

  logic signed [ANGLE_W-1:0] prev_r [NJ];
  logic signed [VEL_W-1:0]   vel_r  [NJ];

  logic                      v1_r, v2_r, v3_r;
  logic                      rdy1, rdy2, rdy3;
  logic                      haz;
  logic                      in_inr;
  logic [IDX_W-1:0]          in_idx;
  logic signed [ANGLE_W-1:0] prev_rd;
  logic signed [VEL_W-1:0]   vold_rd;

  logic [JOINT_W-1:0]        s1_joint_r, s2_joint_r;
  logic                      s1_inr_r, s2_inr_r;
  logic signed [ANGLE_W-1:0] s1_ang_r, s2_ang_r;
  logic signed [DIFF_W-1:0]  s1_diff_r, s1_err_r;
  logic [KP_W-1:0]           s1_kp_r;
  logic                      s1_vneg_r, s2_vneg_r;
  logic [VMAG_W-1:0]         s1_vmag_r;

  logic signed [DIFF_W-1:0]  diff_nxt, err_nxt;
  logic [VMAG_W-1:0]         vmag_nxt;

  logic [QPROD_W-1:0]              s2_qprod_r, qprod_nxt;
  logic signed [VEL_W-1:0]         s2_d400_r, d400_nxt;
  logic signed [P_W-1:0]           s2_p_r, p_nxt;
  logic signed [DIFF_W+9:0]        d400_full;
  logic signed [KP_W+DIFF_W:0]     p_full;

  logic [Q_W-1:0]            q;
  logic signed [Q_W:0]       qs;
  logic signed [VRAW_W-1:0]  vraw;
  logic                      vclip;
  logic signed [VEL_W-1:0]   vel_nxt;
  jpd_mid_t                  s3_r, s3_nxt;
  logic                      wr_en;

  assign in_inr  = in_joint_index < JOINT_W'(NJ);
  assign in_idx  = in_joint_index[IDX_W-1:0];
  assign prev_rd = in_inr ? prev_r[in_idx] : '0;
  assign vold_rd = in_inr ? vel_r[in_idx] : '0;

  // An item of a joint whose update is still in flight waits here.
  assign haz = in_inr &&
               ((v1_r && s1_inr_r && (s1_joint_r == in_joint_index)) ||
                (v2_r && s2_inr_r && (s2_joint_r == in_joint_index)));

  assign rdy3     = !v3_r || mid_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && !haz;

  assign diff_nxt = DIFF_W'(in_measured_angle) - DIFF_W'(prev_rd);
  assign err_nxt  = DIFF_W'(in_reference_angle) - DIFF_W'(in_measured_angle);
  assign vmag_nxt = (vold_rd[VEL_W-1] ? VMAG_W'(-vold_rd) : VMAG_W'(vold_rd)) + VMAG_W'(2);

  assign qprod_nxt = QPROD_W'(s1_vmag_r) * QPROD_W'(DIV5_MUL);
  assign d400_full = s1_diff_r * VEL_GAIN;
  assign d400_nxt  = d400_full[VEL_W-1:0];
  assign p_full    = $signed({1'b0, s1_kp_r}) * s1_err_r;
  assign p_nxt     = p_full[P_W-1:0];

  always_comb begin
    q    = s2_qprod_r[QPROD_W-1:DIV5_SHIFT];
    qs   = s2_vneg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    vraw = VRAW_W'(s2_d400_r) - VRAW_W'(qs);
    vclip = vraw[VRAW_W-1] != vraw[VRAW_W-2];
    if (vclip) begin
      vel_nxt = vraw[VRAW_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      vel_nxt = vraw[VEL_W-1:0];
    end
    s3_nxt.joint = s2_joint_r;
    s3_nxt.inr   = s2_inr_r;
    s3_nxt.clip  = s2_inr_r && vclip;
    s3_nxt.vel   = vel_nxt;
    s3_nxt.pterm = s2_p_r;
  end

  assign wr_en = v2_r && rdy3 && s2_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i < NJ; i++) begin
        prev_r[i] <= home_angle(i);
        vel_r[i]  <= '0;
      end
    end else begin
      if (rdy1) v1_r <= in_valid && in_ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (wr_en) begin
        prev_r[s2_joint_r[IDX_W-1:0]] <= s2_ang_r;
        vel_r[s2_joint_r[IDX_W-1:0]]  <= vel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_joint_r <= in_joint_index;
      s1_inr_r   <= in_inr;
      s1_ang_r   <= in_measured_angle;
      s1_diff_r  <= diff_nxt;
      s1_err_r   <= err_nxt;
      s1_kp_r    <= in_inr ? kp[in_joint_index] : '0;
      s1_vneg_r  <= vold_rd[VEL_W-1];
      s1_vmag_r  <= vmag_nxt;
    end
    if (rdy2) begin
      s2_joint_r <= s1_joint_r;
      s2_inr_r   <= s1_inr_r;
      s2_ang_r   <= s1_ang_r;
      s2_vneg_r  <= s1_vneg_r;
      s2_qprod_r <= qprod_nxt;
      s2_d400_r  <= d400_nxt;
      s2_p_r     <= p_nxt;
    end
    if (rdy3) s3_r <= s3_nxt;
  end

  assign mid_valid = v3_r;
  assign mid       = s3_r;

endmodule
`default_nettype wire

### sv/jpd_trq.sv
// Back stages: derivative term, torque sum, scaling, rounding and saturation.
`default_nettype none
module jpd_trq import jpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 mid_valid,
  output logic                      mid_ready,
  input  wire jpd_mid_t             mid,
  input  wire logic [KD_W-1:0]      kd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [JOINT_W-1:0]        out_joint_tag,
  output logic signed [TORQUE_W-1:0] out_torque_command,
  output logic                      out_torque_saturated
);

  logic                        v4_r, out_valid_r;
  logic                        rdy4, rdy5;
  logic [JOINT_W-1:0]          s4_joint_r;
  logic                        s4_inr_r, s4_clip_r;
  logic signed [SUM_W-1:0]     s4_sum_r, sum_nxt;
  logic signed [KD_W+VEL_W:0]  kdv;

  logic                        neg;
  logic [SUM_W-1:0]            mag, rnd;
  logic signed [SUM_W:0]       sv;
  logic signed [T_W-1:0]       tt;
  logic                        tclip;
  logic signed [TORQUE_W-1:0]  torque_nxt;
  logic                        sat_nxt;

  logic [JOINT_W-1:0]          out_joint_tag_r;
  logic signed [TORQUE_W-1:0]  out_torque_command_r;
  logic                        out_torque_saturated_r;

  assign rdy5      = !out_valid_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign mid_ready = rdy4;

  assign kdv     = $signed({1'b0, kd}) * mid.vel;
  assign sum_nxt = SUM_W'(mid.pterm) - SUM_W'(kdv);

  always_comb begin
    neg   = s4_sum_r[SUM_W-1];
    mag   = neg ? SUM_W'(-s4_sum_r) : SUM_W'(s4_sum_r);
    rnd   = (mag + SUM_W'(SCALE_HALF)) >> SCALE_DN;
    sv    = neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    tt    = T_W'(sv) <<< SCALE_UP;
    tclip = !((&tt[T_W-1:TORQUE_W-1]) || !(|tt[T_W-1:TORQUE_W-1]));
    if (!s4_inr_r) begin
      torque_nxt = '0;
    end else if (tclip) begin
      torque_nxt = tt[T_W-1] ? {1'b1, {(TORQUE_W-1){1'b0}}} : {1'b0, {(TORQUE_W-1){1'b1}}};
    end else begin
      torque_nxt = tt[TORQUE_W-1:0];
    end
    sat_nxt = s4_inr_r && (s4_clip_r || tclip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= mid_valid;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_joint_r <= mid.joint;
      s4_inr_r   <= mid.inr;
      s4_clip_r  <= mid.clip;
      s4_sum_r   <= sum_nxt;
    end
    if (rdy5) begin
      out_joint_tag_r        <= s4_joint_r;
      out_torque_command_r   <= torque_nxt;
      out_torque_saturated_r <= sat_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_joint_tag        = out_joint_tag_r;
  assign out_torque_command   = out_torque_command_r;
  assign out_torque_saturated = out_torque_saturated_r;

endmodule
`default_nettype wire

### sv/joint_pd_filtered_derivative.sv
// Top level of the per-joint PD controller with filtered derivative.
//
//   Port group  Direction  Handshake             Carries
//   in_*        input      in_valid/in_ready     joint index, measured and reference angle
//   out_*       output     out_valid/out_ready   joint tag, torque, saturation flag
//   cfg_*       input      cfg_valid/cfg_ready   register index and write data
//
// One item per cycle is accepted unless a stall or a joint hazard holds in_ready low.
// An item for a joint whose previous item is still in the first two stages waits, so
// the velocity update of that joint is written back before its next item reads it.
// Reset is synchronous, active low: angles go to the home pose, velocities to zero,
// and gains to their defaults. Stages advance independently, so bubbles close up
// while out_ready is low and nothing is dropped or repeated.
`default_nettype none
`include "joint_pd_filtered_derivative_assert.svh"
module joint_pd_filtered_derivative import jpd_pkg::*; #(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [JOINT_W-1:0]         in_joint_index,
  input  wire logic signed [ANGLE_W-1:0]  in_measured_angle,
  input  wire logic signed [ANGLE_W-1:0]  in_reference_angle,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [JOINT_W-1:0]              out_joint_tag,
  output logic signed [TORQUE_W-1:0]      out_torque_command,
  output logic                            out_torque_saturated,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int NJ = eff_joints(NUM_JOINTS);

  kp_bank_t          kp_r;
  logic [KD_W-1:0]   kd_r;
  logic              mid_valid, mid_ready;
  jpd_mid_t          mid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      kd_r <= KD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KD: begin
          kd_r <= cfg_data[KD_W-1:0];
        end
        default: begin
          kp_r[cfg_index] <= cfg_data[KP_W-1:0];
        end
      endcase
    end
  end

  jpd_vel #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_vel (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_joint_index     (in_joint_index),
    .in_measured_angle  (in_measured_angle),
    .in_reference_angle (in_reference_angle),
    .kp                 (kp_r),
    .mid_valid          (mid_valid),
    .mid_ready          (mid_ready),
    .mid                (mid)
  );

  jpd_trq u_trq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .mid_valid            (mid_valid),
    .mid_ready            (mid_ready),
    .mid                  (mid),
    .kd                   (kd_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_joint_tag        (out_joint_tag),
    .out_torque_command   (out_torque_command),
    .out_torque_saturated (out_torque_saturated)
  );

  `JPD_ASSERT_IMP(a_unknown_joint_zero, out_valid && (out_joint_tag >= JOINT_W'(NJ)), (out_torque_command == '0) && !out_torque_saturated, "unknown joint gave a torque or a flag")
  `JPD_ASSERT_IMP(a_mid_joint_range, mid_valid && mid.inr, mid.joint < JOINT_W'(NJ), "known-joint flag on an unknown joint")
  `JPD_ASSERT_IMP(a_mid_clip_known, mid_valid && !mid.inr, !mid.clip, "velocity clip flagged on an unknown joint")
  `JPD_ASSERT_NXT(a_kd_write, cfg_valid && cfg_ready && (cfg_index == REG_KD), kd_r == $past(cfg_data[KD_W-1:0]), "derivative gain write lost")

endmodule
`default_nettype wire

### tb/sv/joint_pd_filtered_derivative_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the joint PD controller: directed table, then random gain phases.
module joint_pd_filtered_derivative_tb;
  import jpd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 80;
  localparam int IDLE_PCT        = 37;
  localparam int GAIN_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [CFG_IDX_W-1:0] REG_KP0    = 3'd0;
  localparam logic [JOINT_W-1:0]   JOINT_NONE = 3'd7;

  localparam longint ANG_HI = (64'sd1 <<< (ANGLE_W - 1)) - 1;
  localparam longint ANG_LO = -(64'sd1 <<< (ANGLE_W - 1));
  localparam longint VEL_HI = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -(64'sd1 <<< (VEL_W - 1));
  localparam longint TQ_HI  = (64'sd1 <<< (TORQUE_W - 1)) - 1;
  localparam longint TQ_LO  = -(64'sd1 <<< (TORQUE_W - 1));

  typedef struct packed {
    logic [JOINT_W-1:0]         tag;
    logic signed [TORQUE_W-1:0] torque;
    logic                       sat;
  } torque_result_t;

  typedef struct packed {
    logic [JOINT_W-1:0]         joint;
    logic signed [ANGLE_W-1:0]  meas;
    logic signed [ANGLE_W-1:0]  tgt;
    logic                       typed;
    logic signed [TORQUE_W-1:0] torque;
    logic                       sat;
  } joint_sample_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  wire                       in_ready;
  logic [JOINT_W-1:0]        in_joint_index = '0;
  logic signed [ANGLE_W-1:0] in_measured_angle = '0;
  logic signed [ANGLE_W-1:0] in_reference_angle = '0;

  wire                       out_valid;
  logic                      out_ready = 1'b0;
  wire [JOINT_W-1:0]         out_joint_tag;
  wire signed [TORQUE_W-1:0] out_torque_command;
  wire                       out_torque_saturated;

  logic                      cfg_valid = 1'b0;
  wire                       cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  torque_result_t torque_expect_q[$];

  logic signed [ANGLE_W-1:0] prev_angle_m [GAIN_COUNT];
  logic signed [VEL_W-1:0]   velocity_m [GAIN_COUNT];
  logic [KP_W-1:0]           kp_m [GAIN_COUNT];
  logic [KD_W-1:0]           kd_m;

  logic signed [ANGLE_W-1:0] last_sent [GAIN_COUNT];
  logic [KP_W-1:0]           kp_next [GAIN_COUNT];
  logic [CFG_DATA_W-1:0]     kd_next;

  int errors = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  joint_pd_filtered_derivative u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_joint_index       (in_joint_index),
    .in_measured_angle    (in_measured_angle),
    .in_reference_angle   (in_reference_angle),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_joint_tag        (out_joint_tag),
    .out_torque_command   (out_torque_command),
    .out_torque_saturated (out_torque_saturated),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip_to(input longint v, input longint lo, input longint hi,
                                     inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] home_pose(input int j);
    longint deg;
    longint num;
    longint h;
    bit unused;
    unused = 1'b0;
    case (j)
      0: deg = 90;
      1: deg = -7;
      2: deg = -13;
      3: deg = 108;
      4: deg = -90;
      5: deg = -90;
      6: deg = 116;
      default: deg = 0;
    endcase
    num = deg * 314 * (64'sd1 <<< ANGLE_FRAC_BITS);
    if (num >= 0) h = (num + 9000) / 18000;
    else h = -((-num + 9000) / 18000);
    return ANGLE_W'(clip_to(h, ANG_LO, ANG_HI, unused));
  endfunction

  task automatic reset_model();
    int j;
    for (j = 0; j < GAIN_COUNT; j++) begin
      prev_angle_m[j] = home_pose(j);
      velocity_m[j] = '0;
      kp_m[j] = KP_RESET[j];
      last_sent[j] = home_pose(j);
    end
    kd_m = KD_RESET;
  endtask

  function automatic torque_result_t predict_torque(input logic [JOINT_W-1:0] j,
                                                    input logic signed [ANGLE_W-1:0] meas,
                                                    input logic signed [ANGLE_W-1:0] tgt);
    torque_result_t r;
    longint v_old;
    longint v_div;
    longint v_new;
    longint sum;
    longint t;
    bit clip;
    r.tag = j;
    r.torque = '0;
    r.sat = 1'b0;
    clip = 1'b0;
    if (j >= NUM_JOINTS_DEF || j >= GAIN_COUNT) return r;
    v_old = velocity_m[j];
    if (v_old >= 0) v_div = (v_old + 2) / 5;
    else v_div = -((-v_old + 2) / 5);
    v_new = 400 * (longint'(meas) - longint'(prev_angle_m[j])) - v_div;
    v_new = clip_to(v_new, VEL_LO, VEL_HI, clip);
    prev_angle_m[j] = meas;
    velocity_m[j] = VEL_W'(v_new);
    sum = longint'(kp_m[j]) * (longint'(tgt) - longint'(meas)) - longint'(kd_m) * v_new;
    if (ANGLE_FRAC_BITS <= 16) t = sum * (64'sd1 <<< SCALE_UP);
    else if (sum >= 0) t = (sum + SCALE_HALF) >>> SCALE_DN;
    else t = -((-sum + SCALE_HALF) >>> SCALE_DN);
    t = clip_to(t, TQ_LO, TQ_HI, clip);
    r.torque = TORQUE_W'(t);
    r.sat = clip;
    return r;
  endfunction

  function automatic joint_sample_t sample_row(input logic [JOINT_W-1:0] j,
                                               input logic signed [ANGLE_W-1:0] meas,
                                               input logic signed [ANGLE_W-1:0] tgt,
                                               input bit typed,
                                               input logic signed [TORQUE_W-1:0] torque,
                                               input bit sat);
    joint_sample_t s;
    s.joint = j;
    s.meas = meas;
    s.tgt = tgt;
    s.typed = typed;
    s.torque = torque;
    s.sat = sat;
    return s;
  endfunction

  function automatic joint_sample_t random_sample(input logic [JOINT_W-1:0] j);
    logic signed [ANGLE_W-1:0] raw;
    longint m;
    longint t;
    int mode;
    bit unused;
    unused = 1'b0;
    mode = $urandom_range(99);
    raw = ANGLE_W'($urandom);
    if (j >= GAIN_COUNT || mode < 15) m = raw;
    else if (mode < 60) m = longint'(last_sent[j]) + int'($urandom_range(510)) - 255;
    else m = longint'(last_sent[j]) + int'($urandom_range(16382)) - 8191;
    m = clip_to(m, ANG_LO, ANG_HI, unused);
    raw = ANGLE_W'($urandom);
    if ($urandom_range(99) < 20) t = raw;
    else t = clip_to(m + int'($urandom_range(4094)) - 2047, ANG_LO, ANG_HI, unused);
    if (j < GAIN_COUNT) last_sent[j] = ANGLE_W'(m);
    return sample_row(j, ANGLE_W'(m), ANGLE_W'(t), 1'b0, '0, 1'b0);
  endfunction

  task automatic send_sample(input joint_sample_t s);
    torque_result_t r;
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_index <= s.joint;
    in_measured_angle <= s.meas;
    in_reference_angle <= s.tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_torque(s.joint, s.meas, s.tgt);
    if (s.typed) begin
      r.tag = s.joint;
      r.torque = s.torque;
      r.sat = s.sat;
    end
    torque_expect_q.push_back(r);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (torque_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_KD) kd_m = data[KD_W-1:0];
    else if (idx < GAIN_COUNT) kp_m[idx] = data[KP_W-1:0];
  endtask

  task automatic program_gains();
    int i;
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (i = 0; i < GAIN_COUNT; i++) begin
      write_reg(REG_KP0 + CFG_IDX_W'(i), CFG_DATA_W'(kp_next[i]));
    end
    write_reg(REG_KD, kd_next);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    torque_result_t exp_r;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (torque_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual tag %0d torque %0d sat %0b",
                   $time, out_joint_tag, out_torque_command, out_torque_saturated);
        end else begin
          exp_r = torque_expect_q.pop_front();
          if (out_joint_tag !== exp_r.tag) begin
            errors++;
            $display("%0t: joint_tag mismatch, expected %0d, actual %0d",
                     $time, exp_r.tag, out_joint_tag);
          end
          if (out_torque_command !== exp_r.torque) begin
            errors++;
            $display("%0t: torque_command mismatch, expected %0d, actual %0d",
                     $time, exp_r.torque, out_torque_command);
          end
          if (out_torque_saturated !== exp_r.sat) begin
            errors++;
            $display("%0t: torque_saturated mismatch, expected %0b, actual %0b",
                     $time, exp_r.sat, out_torque_saturated);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("joint_pd_filtered_derivative_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    joint_sample_t rows[$];
    int phase;
    int sent;
    int i;
    bit held;
    bit paused;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed ones: both torque limits from the home pose, and the joint with no gain.
    rows.push_back(sample_row(3'd0, -18'sd131072, 18'sd131071, 1'b1, 32'sh7FFFFFFF, 1'b1));
    rows.push_back(sample_row(3'd1, 18'sd131071, -18'sd131072, 1'b1, 32'sh80000000, 1'b1));
    rows.push_back(sample_row(JOINT_NONE, 18'sd12345, -18'sd5, 1'b1, '0, 1'b0));
    rows.push_back(sample_row(JOINT_NONE, -18'sd131072, 18'sd131071, 1'b1, '0, 1'b0));
    rows.push_back(sample_row(3'd2, 18'sd0, 18'sd0, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd3, 18'sd131071, 18'sd131071, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd3, 18'sd131071, 18'sd131071, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd3, -18'sd131072, -18'sd131072, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd4, 18'sd0, -18'sd131072, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd5, -18'sd1, 18'sd0, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd6, 18'sd1, -18'sd1, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd6, 18'sd131071, -18'sd131072, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd6, -18'sd131072, 18'sd131071, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd0, -18'sd131072, -18'sd131072, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd0, 18'sd0, 18'sd0, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd1, 18'sd131071, 18'sd131071, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd2, -18'sd131072, 18'sd131071, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd4, 18'sd131071, 18'sd0, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(3'd5, -18'sd131072, -18'sd131072, 1'b0, '0, 1'b0));
    rows.push_back(sample_row(JOINT_NONE, 18'sd0, 18'sd0, 1'b1, '0, 1'b0));
    foreach (rows[k]) send_sample(rows[k]);
    end_burst();

    for (phase = 0; phase < GAIN_PHASES; phase++) begin
      for (i = 0; i < GAIN_COUNT; i++) begin
        if (phase == 0) kp_next[i] = '1;
        else if (phase == 1) kp_next[i] = '0;
        else if ($urandom_range(1)) kp_next[i] = KP_W'($urandom_range(4095));
        else kp_next[i] = KP_W'($urandom_range(600));
      end
      if (phase == 0) kd_next = 12'h3FF;
      else if (phase == 1) kd_next = 12'hC00;
      else if ($urandom_range(1)) kd_next = CFG_DATA_W'($urandom);
      else kd_next = {2'($urandom), 10'($urandom_range(40))};
      program_gains();

      idle_en = (phase != 3);
      held = 1'b0;
      paused = 1'b0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == 2 && !held && sent >= 10) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
        if (phase == 4 && !paused && sent >= 50) begin
          paused = 1'b1;
          end_burst();
          wait_results();
        end
        if ($urandom_range(99) < 30) begin
          for (i = 0; i < GAIN_COUNT; i++) send_sample(random_sample(JOINT_W'(i)));
          sent += GAIN_COUNT;
        end else begin
          if ($urandom_range(99) < 8) send_sample(random_sample(JOINT_NONE));
          else send_sample(random_sample(JOINT_W'($urandom_range(GAIN_COUNT - 1))));
          sent++;
        end
      end
      end_burst();
    end
    idle_en = 1'b1;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("joint_pd_filtered_derivative_tb: done, clean");
    else $display("joint_pd_filtered_derivative_tb: done, errors");
    $finish;
  end

endmodule

### joint_pd_filtered_derivative.f
+incdir+sv
sv/jpd_pkg.sv
sv/jpd_vel.sv
sv/jpd_trq.sv
sv/joint_pd_filtered_derivative.sv
tb/sv/joint_pd_filtered_derivative_tb.sv
